@@ sv/rrsd_pkg.sv @@
// Shared types and constants for the raster run segment detector.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package rrsd_pkg;

   localparam int MAX_DIM     = 4096;
   localparam int POS_W       = 12;
   localparam int PIX_W       = 8;
   localparam int SKIP_W      = 8;
   localparam int SCAN_W      = 13;
   localparam int DARK_W      = 9;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;
   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 40;

   localparam logic [PIX_W-1:0]  BRIGHT_LEVEL   = 8'd1;
   localparam logic [DARK_W-1:0] DARK_MAX       = 9'd511;
   localparam logic [POS_W-1:0]  MIN_RUN_RESET  = 12'd3;
   localparam logic [SCAN_W-1:0] SCAN_LEN_RESET = SCAN_W'(MAX_DIM & 'h1FFF);

   typedef enum logic [1:0] {
      REG_SKIP_PIXELS    = 2'd0,
      REG_MIN_RUN_LENGTH = 2'd1,
      REG_SCAN_LENGTH    = 2'd2,
      REG_SCAN_VERTICAL  = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [SKIP_W-1:0] skip_pixels;
      logic [POS_W-1:0]  min_run_length;
      logic [SCAN_W-1:0] scan_length;
      logic              scan_vertical;
   } cfg_type;

   typedef struct packed {
      logic              run_open;
      logic [POS_W-1:0]  run_first;
      logic [DARK_W-1:0] dark_count;
   } run_state_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_value;
      logic [POS_W-1:0] along_pos;
      logic [POS_W-1:0] across_pos;
   } pixel_type;

   typedef struct packed {
      logic [POS_W-1:0] seg_start;
      logic [POS_W-1:0] seg_end;
      logic [POS_W-1:0] seg_line;
      logic             seg_vertical;
   } segment_type;

endpackage

@@ sv/rrsd_csr.sv @@
// Configuration register file of the run segment detector, APB-style access.
// Depends on rrsd_pkg.
`timescale 1ns / 1ps

module rrsd_csr
   import rrsd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_sel;
   logic          wr_en;

   assign reg_sel    = reg_index_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_SKIP_PIXELS:    cfg_in.skip_pixels    = csr_pwdata[SKIP_W-1:0];
            REG_MIN_RUN_LENGTH: cfg_in.min_run_length = csr_pwdata[POS_W-1:0];
            REG_SCAN_LENGTH:    cfg_in.scan_length    = csr_pwdata[SCAN_W-1:0];
            REG_SCAN_VERTICAL:  cfg_in.scan_vertical  = csr_pwdata[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_SKIP_PIXELS:    csr_prdata = CSR_DATA_W'(cfg_ff.skip_pixels);
         REG_MIN_RUN_LENGTH: csr_prdata = CSR_DATA_W'(cfg_ff.min_run_length);
         REG_SCAN_LENGTH:    csr_prdata = CSR_DATA_W'(cfg_ff.scan_length);
         REG_SCAN_VERTICAL:  csr_prdata = CSR_DATA_W'(cfg_ff.scan_vertical);
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.skip_pixels    <= '0;
         cfg_ff.min_run_length <= MIN_RUN_RESET;
         cfg_ff.scan_length    <= SCAN_LEN_RESET;
         cfg_ff.scan_vertical  <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ sv/rrsd_step.sv @@
// Per-pixel run logic: next run state and the segment, if any, for one pixel.
// Depends on rrsd_pkg; purely combinational.
`timescale 1ns / 1ps

module rrsd_step
   import rrsd_pkg::*;
(
   input  cfg_type       cfg,
   input  pixel_type     pix,
   input  run_state_type cur,
   output run_state_type nxt,
   output logic          emit,
   output segment_type   seg
);

   run_state_type    base;
   run_state_type    upd;
   logic [POS_W-1:0] span;
   logic             long_enough;
   logic             closing;
   logic             line_end;

   always_comb begin
      // clear at line start
      base = cur;
      if (pix.along_pos == '0) begin
         base = '0;
      end

      upd = base;
      if (pix.pixel_value > BRIGHT_LEVEL) begin
         upd.run_open   = 1'b1;
         upd.run_first  = base.run_open ? base.run_first : pix.along_pos;
         upd.dark_count = '0;
      end else if (base.dark_count < DARK_MAX) begin
         upd.dark_count = base.dark_count + DARK_W'(1);
      end

      span        = pix.along_pos - upd.run_first;
      long_enough = span >= cfg.min_run_length;
      closing     = upd.dark_count > DARK_W'(cfg.skip_pixels);
      line_end    = ({1'b0, pix.along_pos} + SCAN_W'(1)) == cfg.scan_length;

      nxt               = upd;
      emit              = 1'b0;
      seg.seg_start     = upd.run_first;
      seg.seg_end       = pix.along_pos;
      seg.seg_line      = pix.across_pos;
      seg.seg_vertical  = cfg.scan_vertical;

      if (upd.run_open) begin
         if (closing) begin
            nxt.run_open   = 1'b0;
            nxt.run_first  = pix.along_pos;
            nxt.dark_count = '0;
            emit           = long_enough;
            seg.seg_end    = pix.along_pos - (POS_W'(cfg.skip_pixels) + POS_W'(1));
         end else begin
            emit = long_enough & line_end;
         end
      end
   end

endmodule

@@ sv/raster_run_segment_detector.sv @@
// Raster run segment detector: one pixel per clock in, line segments out.
// Accepts a pixel in every cycle while the result side keeps up; each pixel is
// registered, passes the combinational run logic and leaves at most one
// segment in the output register. The run state is a single register
// updated once per pixel, which sets the rate at one pixel per clock while
// the output is not stalled. Configure only while no pixel is in flight.
// Depends on rrsd_pkg, rrsd_csr and rrsd_step.
`timescale 1ns / 1ps

module raster_run_segment_detector
   import rrsd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata: pixel_value[7:0], along_pos[19:8], across_pos[31:20]
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // rsp_tdata: seg_start[11:0], seg_end[23:12], seg_line[35:24], zero[39:36]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // rsp_tuser: seg_vertical[0]
   output logic                  rsp_tuser,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type       cfg;
   pixel_type     pix_ff;
   pixel_type     pix_in;
   logic          pix_valid_ff;
   logic          pix_valid_in;
   run_state_type run_ff;
   run_state_type run_in;
   run_state_type run_nxt;
   segment_type   seg;
   segment_type   seg_ff;
   segment_type   seg_in;
   logic          seg_valid_ff;
   logic          seg_valid_in;
   logic          emit;
   logic          out_free;
   logic          advance;
   logic          req_take;

   rrsd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rrsd_step u_step (
      .cfg  (cfg),
      .pix  (pix_ff),
      .cur  (run_ff),
      .nxt  (run_nxt),
      .emit (emit),
      .seg  (seg)
   );

   assign out_free   = ~seg_valid_ff | rsp_tready;
   assign advance    = pix_valid_ff & out_free;
   assign req_tready = ~pix_valid_ff | advance;
   assign req_take   = req_tvalid & req_tready;

   always_comb begin
      pix_in       = pix_ff;
      pix_valid_in = pix_valid_ff & ~advance;
      if (req_take) begin
         pix_in.pixel_value = req_tdata[7:0];
         pix_in.along_pos   = req_tdata[19:8];
         pix_in.across_pos  = req_tdata[31:20];
         pix_valid_in       = 1'b1;
      end

      run_in = advance ? run_nxt : run_ff;

      seg_in       = seg_ff;
      seg_valid_in = seg_valid_ff & ~rsp_tready;
      if (advance) begin
         seg_in       = seg;
         seg_valid_in = emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_valid_ff <= 1'b0;
         seg_valid_ff <= 1'b0;
         run_ff       <= '0;
      end else begin
         pix_valid_ff <= pix_valid_in;
         seg_valid_ff <= seg_valid_in;
         run_ff       <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff <= pix_in;
      seg_ff <= seg_in;
   end

   assign rsp_tvalid = seg_valid_ff;
   assign rsp_tdata  = {4'b0000, seg_ff.seg_line, seg_ff.seg_end, seg_ff.seg_start};
   assign rsp_tuser  = seg_ff.seg_vertical;

endmodule
